@@ rtl/rect_union_clamp_query_assert.svh @@
// Assertion macros for the rectangle union clamp/query block.
// Used by the top level; needs i_clk and i_rst_n in scope.
`ifndef RECT_UNION_CLAMP_QUERY_ASSERT_SVH
`define RECT_UNION_CLAMP_QUERY_ASSERT_SVH

// same-cycle implication
`define RUCQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RUCQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rucq_pkg.sv @@
// Shared types, codes and helpers of the rectangle union clamp/query block.
// No dependencies.
`default_nettype none
package rucq_pkg;
    localparam int COORD_W   = 24;
    localparam int MAX_RECTS = 64;
    localparam int IDX_W     = $clog2(MAX_RECTS);
    localparam int CNT_W     = $clog2(MAX_RECTS + 1);
    localparam int DIST_W    = 50;
    localparam int TOL_W     = 16;
    localparam int HALF_W    = 23;
    localparam int EXT_W     = COORD_W + 2;
    localparam int MAG_W     = COORD_W + 1;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_BUILD = 2'd2;
    localparam logic [1:0] MODE_QUERY = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam logic [1:0] CFG_TOL    = 2'd0;
    localparam logic [1:0] CFG_HALF_W = 2'd1;
    localparam logic [1:0] CFG_HALF_H = 2'd2;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [EXT_W-1:0]   t_ext;

    typedef struct packed {
        t_coord l;
        t_coord r;
        t_coord t;
        t_coord b;
    } t_rect;

    // edge has a neighbor abutting it
    typedef struct packed {
        logic l;
        logic r;
        logic t;
        logic b;
    } t_adj;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_B_RDI,
        S_B_LATI,
        S_B_SCAN,
        S_B_ARD,
        S_B_AWR,
        S_Q_RD,
        S_Q_CLAMP,
        S_Q_SQX,
        S_Q_SQY,
        S_FIN
    } t_state;

    function automatic t_ext ext(input t_coord v);
        ext = {{2{v[COORD_W-1]}}, v};
    endfunction

    function automatic t_coord sat_coord(input t_ext v);
        t_ext hi;
        t_ext lo;
        hi = {3'b000, {(COORD_W-1){1'b1}}};
        lo = {3'b111, {(COORD_W-1){1'b0}}};
        if (v > hi) begin
            sat_coord = hi[COORD_W-1:0];
        end else if (v < lo) begin
            sat_coord = lo[COORD_W-1:0];
        end else begin
            sat_coord = v[COORD_W-1:0];
        end
    endfunction
endpackage
`default_nettype wire

@@ rtl/rucq_if.sv @@
// Input and result channel interfaces (valid/ready plus payload).
// Depends on rucq_pkg.
`default_nettype none
interface rucq_in_if;
    import rucq_pkg::*;
    logic         valid;
    logic         ready;
    logic [1:0]   mode;
    t_coord       coord_x;
    t_coord       coord_y;
    logic [HALF_W-1:0] rect_width;
    logic [HALF_W-1:0] rect_height;
    modport source (output valid, mode, coord_x, coord_y, rect_width, rect_height,
                    input ready);
    modport sink   (input valid, mode, coord_x, coord_y, rect_width, rect_height,
                    output ready);
endinterface

interface rucq_out_if;
    import rucq_pkg::*;
    logic              valid;
    logic              ready;
    logic              inside_res;
    t_coord            near_x;
    t_coord            near_y;
    logic [DIST_W-1:0] near_dist_sq;
    logic [1:0]        status;
    logic [CNT_W-1:0]  entry_count;
    modport source (output valid, inside_res, near_x, near_y, near_dist_sq, status,
                    entry_count, input ready);
    modport sink   (input valid, inside_res, near_x, near_y, near_dist_sq, status,
                    entry_count, output ready);
endinterface
`default_nettype wire

@@ rtl/rucq_adj.sv @@
// Adjacency test of one rectangle against one other, on the edges as they stand.
// Depends on rucq_pkg.
`default_nettype none
module rucq_adj
    import rucq_pkg::*;
(
    input  t_rect            i_ei,
    input  t_rect            i_ej,
    input  logic [TOL_W-1:0] i_tol,
    output t_adj             o_hit
);
    t_ext tol;
    logic ovx;
    logic ovy;

    function automatic logic near_edge(input t_ext a, input t_ext b, input t_ext tl);
        t_ext d;
        d = a - b;
        if (d < 0) begin
            d = -d;
        end
        near_edge = (d < tl);
    endfunction

    assign tol = {{(EXT_W-TOL_W){1'b0}}, i_tol};
    assign ovy = (ext(i_ei.t) < ext(i_ej.b) - tol) && (ext(i_ei.b) > ext(i_ej.t) + tol);
    assign ovx = (ext(i_ei.l) < ext(i_ej.r) - tol) && (ext(i_ei.r) > ext(i_ej.l) + tol);

    assign o_hit.l = ovy && near_edge(ext(i_ei.l), ext(i_ej.r), tol);
    assign o_hit.r = ovy && near_edge(ext(i_ei.r), ext(i_ej.l), tol);
    assign o_hit.t = ovx && near_edge(ext(i_ei.t), ext(i_ej.b), tol);
    assign o_hit.b = ovx && near_edge(ext(i_ei.b), ext(i_ej.t), tol);
endmodule
`default_nettype wire

@@ rtl/rect_union_clamp_query.sv @@
// Top level of the rectangle union clamp/query block.
// Depends on rucq_pkg, rucq_if, rucq_adj and rect_union_clamp_query_assert.svh.
`default_nettype none
// Holds up to MAX_RECTS (64) axis-aligned rectangles in one edge memory and
// works one transaction at a time under a small sequencer; i_in.ready is high
// only while idle. A clear goes straight to the result; an add writes one
// entry first, unless the table is full and the add is dropped. A query
// walks the held rectangles through one clamp stage and one shared squaring
// multiplier that is used twice per rectangle. A build first scans every
// pair through the adjacency comparator with the edges as they stand,
// keeping per-rectangle flags in a small flag memory, then rewrites each
// rectangle once. The edge memory has a single read port, which sets the
// one-rectangle-per-step pace. The result sits in an output register, so the
// next transaction can start while the previous result waits. Configuration
// writes land at once and must only be made while idle.
module rect_union_clamp_query
    import rucq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [HALF_W-1:0] i_cfg_data,
    rucq_in_if.sink                i_in,
    rucq_out_if.source             o_out
);
    // configuration
    logic [TOL_W-1:0]  r_tol;
    logic [HALF_W-1:0] r_half_w;
    logic [HALF_W-1:0] r_half_h;

    // sequencer
    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;

    // latched transaction
    logic [1:0]        r_mode;
    t_coord            r_px;
    t_coord            r_py;
    logic [HALF_W-2:0] r_hw;
    logic [HALF_W-2:0] r_hh;

    // memories
    t_rect r_mem [MAX_RECTS];
    t_adj  r_flag_mem [MAX_RECTS];
    t_rect r_rd_data;
    t_adj  r_flag_rd;

    logic [IDX_W-1:0] s_rd_addr;
    logic             s_we;
    t_rect            s_wr_data;
    logic             s_flag_we;

    // build scan
    t_rect r_ei;
    t_adj  r_hit;
    t_adj  s_hit;
    t_adj  s_hit_acc;

    // query datapath
    logic              r_inside;
    logic              r_found;
    t_coord            r_cx;
    t_coord            r_cy;
    logic [MAG_W-1:0]  r_dx;
    logic [MAG_W-1:0]  r_dy;
    logic [DIST_W-1:0] r_sqx;
    t_coord            r_best_x;
    t_coord            r_best_y;
    logic [DIST_W-1:0] r_best_d;
    logic [1:0]        r_status;

    // result register
    logic              r_out_valid;
    logic              r_o_inside;
    t_coord            r_o_x;
    t_coord            r_o_y;
    logic [DIST_W-1:0] r_o_d;
    logic [1:0]        r_o_status;
    logic [CNT_W-1:0]  r_o_count;

    logic              s_accept;
    logic              s_full;
    logic              s_last_i;
    logic              s_last_j;
    logic              s_fin_load;
    t_rect             s_add_rect;
    t_rect             s_shrunk;
    t_coord            s_cx;
    t_coord            s_cy;
    logic              s_in_now;
    logic signed [MAG_W-1:0] s_dxs;
    logic signed [MAG_W-1:0] s_dys;
    logic [MAG_W-1:0]  s_mul_a;
    logic [DIST_W-1:0] s_prod;
    logic [DIST_W:0]   s_dsum;
    logic [DIST_W-1:0] s_d;

    assign s_accept   = i_in.valid && i_in.ready;
    assign s_full     = (r_count == CNT_W'(MAX_RECTS));
    assign s_last_i   = ((CNT_W'(r_i) + CNT_W'(1)) == r_count);
    assign s_last_j   = ((CNT_W'(r_j) + CNT_W'(1)) == r_count);
    assign s_fin_load = (r_state == S_FIN) && (!r_out_valid || o_out.ready);

    assign i_in.ready = (r_state == S_IDLE);

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol    <= TOL_W'(1);
            r_half_w <= '0;
            r_half_h <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TOL:    r_tol    <= i_cfg_data[TOL_W-1:0];
                CFG_HALF_W: r_half_w <= i_cfg_data;
                CFG_HALF_H: r_half_h <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    unique case (i_in.mode)
                        MODE_CLEAR: n_state = S_FIN;
                        MODE_ADD:   n_state = s_full ? S_FIN : S_ADD;
                        MODE_BUILD: n_state = (r_count == '0) ? S_FIN : S_B_RDI;
                        MODE_QUERY: n_state = (r_count == '0) ? S_FIN : S_Q_RD;
                        default:    n_state = S_FIN;
                    endcase
                end
            end
            S_ADD:     n_state = S_FIN;
            S_B_RDI:   n_state = S_B_LATI;
            S_B_LATI:  n_state = S_B_SCAN;
            S_B_SCAN: begin
                if (s_last_j) begin
                    n_state = s_last_i ? S_B_ARD : S_B_RDI;
                end
            end
            S_B_ARD:   n_state = S_B_AWR;
            S_B_AWR:   n_state = s_last_i ? S_FIN : S_B_ARD;
            S_Q_RD:    n_state = S_Q_CLAMP;
            S_Q_CLAMP: n_state = S_Q_SQX;
            S_Q_SQX:   n_state = S_Q_SQY;
            S_Q_SQY:   n_state = s_last_i ? S_FIN : S_Q_RD;
            S_FIN:     n_state = s_fin_load ? S_IDLE : S_FIN;
            default:   n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: memory addressing and write strobes
    always_comb begin
        s_rd_addr = r_i;
        s_we      = 1'b0;
        s_wr_data = s_add_rect;
        s_flag_we = 1'b0;
        unique case (r_state)
            S_B_LATI: s_rd_addr = r_j;
            S_B_SCAN: begin
                s_rd_addr = r_j + IDX_W'(1);
                s_flag_we = s_last_j;
            end
            S_ADD: begin
                s_we      = 1'b1;
                s_wr_data = s_add_rect;
            end
            S_B_AWR: begin
                s_we      = 1'b1;
                s_wr_data = s_shrunk;
            end
            default: s_rd_addr = r_i;
        endcase
    end

    // edge memory and adjacency flag memory
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_mem[r_state == S_ADD ? r_count[IDX_W-1:0] : r_i] <= s_wr_data;
        end
        if (s_flag_we) begin
            r_flag_mem[r_i] <= s_hit_acc;
        end
        r_rd_data <= r_mem[s_rd_addr];
        r_flag_rd <= r_flag_mem[s_rd_addr];
    end

    // add: center and half size to edges
    always_comb begin
        s_add_rect.l = sat_coord(ext(r_px) - t_ext'({3'b000, r_hw}));
        s_add_rect.r = sat_coord(ext(r_px) + t_ext'({3'b000, r_hw}));
        s_add_rect.t = sat_coord(ext(r_py) - t_ext'({3'b000, r_hh}));
        s_add_rect.b = sat_coord(ext(r_py) + t_ext'({3'b000, r_hh}));
    end

    // build: pair test against the rectangle under scan
    rucq_adj u_adj (
        .i_ei  (r_ei),
        .i_ej  (r_rd_data),
        .i_tol (r_tol),
        .o_hit (s_hit)
    );

    assign s_hit_acc = (r_j == r_i) ? r_hit : (r_hit | s_hit);

    // build: free edges move inward by the agent half size
    always_comb begin
        s_shrunk = r_rd_data;
        if (!r_flag_rd.l) s_shrunk.l = sat_coord(ext(r_rd_data.l) + t_ext'({3'b000, r_half_w}));
        if (!r_flag_rd.r) s_shrunk.r = sat_coord(ext(r_rd_data.r) - t_ext'({3'b000, r_half_w}));
        if (!r_flag_rd.t) s_shrunk.t = sat_coord(ext(r_rd_data.t) + t_ext'({3'b000, r_half_h}));
        if (!r_flag_rd.b) s_shrunk.b = sat_coord(ext(r_rd_data.b) - t_ext'({3'b000, r_half_h}));
    end

    // query: clamp low edge first, then high edge
    always_comb begin
        s_cx = (r_px < r_rd_data.l) ? r_rd_data.l : r_px;
        if (s_cx > r_rd_data.r) s_cx = r_rd_data.r;
        s_cy = (r_py < r_rd_data.t) ? r_rd_data.t : r_py;
        if (s_cy > r_rd_data.b) s_cy = r_rd_data.b;
        s_in_now = (r_px >= r_rd_data.l) && (r_px <= r_rd_data.r)
                && (r_py >= r_rd_data.t) && (r_py <= r_rd_data.b);
        s_dxs = {s_cx[COORD_W-1], s_cx} - {r_px[COORD_W-1], r_px};
        s_dys = {s_cy[COORD_W-1], s_cy} - {r_py[COORD_W-1], r_py};
    end

    // shared squaring multiplier: x offset, then y offset
    assign s_mul_a = (r_state == S_Q_SQX) ? r_dx : r_dy;
    assign s_prod  = DIST_W'(s_mul_a) * DIST_W'(s_mul_a);
    assign s_dsum  = {1'b0, r_sqx} + {1'b0, s_prod};
    assign s_d     = s_dsum[DIST_W-1:0];

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_i <= '0;
                        r_j <= '0;
                        if (i_in.mode == MODE_CLEAR) begin
                            r_count <= '0;
                        end
                    end
                end
                S_ADD:   r_count <= r_count + CNT_W'(1);
                S_B_RDI: r_j <= '0;
                S_B_SCAN: begin
                    r_j <= r_j + IDX_W'(1);
                    if (s_last_j) begin
                        r_i <= s_last_i ? '0 : r_i + IDX_W'(1);
                    end
                end
                S_B_AWR: r_i <= r_i + IDX_W'(1);
                S_Q_SQY: r_i <= r_i + IDX_W'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_mode   <= i_in.mode;
            r_px     <= i_in.coord_x;
            r_py     <= i_in.coord_y;
            r_hw     <= i_in.rect_width[HALF_W-1:1];
            r_hh     <= i_in.rect_height[HALF_W-1:1];
            r_inside <= 1'b0;
            r_found  <= 1'b0;
            r_best_x <= i_in.coord_x;
            r_best_y <= i_in.coord_y;
            r_best_d <= DIST_MAX;
            r_status <= STAT_OK;
            if (i_in.mode == MODE_ADD && s_full) begin
                r_status <= STAT_FULL;
            end
            if (i_in.mode == MODE_QUERY && r_count == '0) begin
                r_status <= STAT_EMPTY;
            end
        end
        if (r_state == S_B_LATI) begin
            r_ei  <= r_rd_data;
            r_hit <= '0;
        end
        if (r_state == S_B_SCAN) begin
            r_hit <= s_last_j ? '0 : s_hit_acc;
        end
        if (r_state == S_Q_CLAMP) begin
            r_cx     <= s_cx;
            r_cy     <= s_cy;
            r_dx     <= s_dxs[MAG_W-1] ? MAG_W'(-s_dxs) : MAG_W'(s_dxs);
            r_dy     <= s_dys[MAG_W-1] ? MAG_W'(-s_dys) : MAG_W'(s_dys);
            r_inside <= r_inside | s_in_now;
        end
        if (r_state == S_Q_SQX) begin
            r_sqx <= s_prod;
        end
        // first minimum wins
        if (r_state == S_Q_SQY && (!r_found || s_d < r_best_d)) begin
            r_found  <= 1'b1;
            r_best_d <= s_d;
            r_best_x <= r_cx;
            r_best_y <= r_cy;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fin_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fin_load) begin
            r_o_status <= r_status;
            r_o_count  <= r_count;
            if (r_mode == MODE_QUERY) begin
                r_o_inside <= r_inside;
                r_o_x      <= r_best_x;
                r_o_y      <= r_best_y;
                r_o_d      <= r_best_d;
            end else begin
                r_o_inside <= 1'b0;
                r_o_x      <= '0;
                r_o_y      <= '0;
                r_o_d      <= '0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.inside_res   = r_o_inside;
    assign o_out.near_x       = r_o_x;
    assign o_out.near_y       = r_o_y;
    assign o_out.near_dist_sq = r_o_d;
    assign o_out.status       = r_o_status;
    assign o_out.entry_count  = r_o_count;

    `include "rect_union_clamp_query_assert.svh"

    `RUCQ_ASSERT_NOW(a_full_count, o_out.valid && o_out.status == STAT_FULL,
        o_out.entry_count == CNT_W'(MAX_RECTS), "dropped add with table not full")
    `RUCQ_ASSERT_NOW(a_empty_query, o_out.valid && o_out.status == STAT_EMPTY,
        !o_out.inside_res && o_out.near_dist_sq == DIST_MAX, "empty query result wrong")
    `RUCQ_ASSERT_NEXT(a_query_start, s_accept && i_in.mode == MODE_QUERY && r_count != '0,
        r_state == S_Q_RD, "query did not start scan")
    `RUCQ_ASSERT_NOW(a_count_bound, r_state != S_IDLE,
        r_count <= CNT_W'(MAX_RECTS), "held count beyond table size")
endmodule
`default_nettype wire

@@ bench/rect_union_clamp_query_test.sv @@
// Self-checking testbench for rect_union_clamp_query: random and directed tables and queries.
// Depends on rucq_pkg, rucq_if and the block RTL; needs nothing else.
`default_nettype none

module rect_union_clamp_query_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rucq_pkg::*;

    // Table model plus the queue of expected results, one per accepted transaction.
    class rect_scoreboard;
        typedef struct {
            logic              in_res;
            longint            nx;
            longint            ny;
            logic [DIST_W-1:0] dsq;
            logic [1:0]        status;
            int                count;
        } rect_result_t;

        longint       le[MAX_RECTS];
        longint       re[MAX_RECTS];
        longint       te[MAX_RECTS];
        longint       be[MAX_RECTS];
        int           held;
        longint       tol;
        longint       half_x;
        longint       half_y;
        rect_result_t pending[$];
        int           errors;

        function void reset_state();
            held = 0;
            tol = 1;
            half_x = 0;
            half_y = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, longint v);
            if (idx == CFG_TOL) tol = v & 16'hFFFF;
            else if (idx == CFG_HALF_W) half_x = v & 23'h7FFFFF;
            else if (idx == CFG_HALF_H) half_y = v & 23'h7FFFFF;
        endfunction

        function longint clip(longint v);
            longint hi;
            hi = (64'sd1 <<< (COORD_W - 1)) - 1;
            if (v > hi) return hi;
            if (v < -hi - 1) return -hi - 1;
            return v;
        endfunction

        function longint mag(longint v);
            return v < 0 ? -v : v;
        endfunction

        // adjacency is decided on a snapshot, shrinks land together
        function void shrink_free_edges();
            longint sl[MAX_RECTS], sr[MAX_RECTS], st[MAX_RECTS], sb[MAX_RECTS];
            bit     al, ar, at, ab, ovx, ovy;
            sl = le; sr = re; st = te; sb = be;
            for (int i = 0; i < held; i++) begin
                al = 0; ar = 0; at = 0; ab = 0;
                for (int j = 0; j < held; j++) begin
                    if (i == j) continue;
                    ovy = st[i] < sb[j] - tol && sb[i] > st[j] + tol;
                    ovx = sl[i] < sr[j] - tol && sr[i] > sl[j] + tol;
                    if (ovy && mag(sl[i] - sr[j]) < tol) al = 1;
                    if (ovy && mag(sr[i] - sl[j]) < tol) ar = 1;
                    if (ovx && mag(st[i] - sb[j]) < tol) at = 1;
                    if (ovx && mag(sb[i] - st[j]) < tol) ab = 1;
                end
                if (!al) le[i] = clip(sl[i] + half_x);
                if (!ar) re[i] = clip(sr[i] - half_x);
                if (!at) te[i] = clip(st[i] + half_y);
                if (!ab) be[i] = clip(sb[i] - half_y);
            end
        endfunction

        function void note_item(logic [1:0] mode, longint px, longint py,
                                longint w, longint h);
            rect_result_t r;
            longint       cx, cy;
            logic [63:0]  d;
            r = '{0, 0, 0, '0, STAT_OK, 0};
            case (mode)
                MODE_CLEAR: held = 0;
                MODE_ADD: begin
                    if (held >= MAX_RECTS) begin
                        r.status = STAT_FULL;
                    end else begin
                        le[held] = clip(px - (w >> 1));
                        re[held] = clip(px + (w >> 1));
                        te[held] = clip(py - (h >> 1));
                        be[held] = clip(py + (h >> 1));
                        held++;
                    end
                end
                MODE_BUILD: shrink_free_edges();
                default: begin
                    r.nx = px;
                    r.ny = py;
                    r.dsq = DIST_MAX;
                    if (held == 0) r.status = STAT_EMPTY;
                    for (int i = 0; i < held; i++) begin
                        if (px >= le[i] && px <= re[i] && py >= te[i] && py <= be[i])
                            r.in_res = 1;
                        cx = px;
                        cy = py;
                        if (cx < le[i]) cx = le[i];
                        if (cx > re[i]) cx = re[i];
                        if (cy < te[i]) cy = te[i];
                        if (cy > be[i]) cy = be[i];
                        // diffs fit in 25 bits, so the sum never reaches the cap
                        d = (cx - px) * (cx - px) + (cy - py) * (cy - py);
                        if (i == 0 || d < r.dsq) begin
                            r.dsq = d[DIST_W-1:0];
                            r.nx = cx;
                            r.ny = cy;
                        end
                    end
                end
            endcase
            r.count = held;
            pending = {pending, r};
        endfunction

        function void check(logic got_in, t_coord nx, t_coord ny, logic [DIST_W-1:0] got_dsq,
                            logic [1:0] status, logic [CNT_W-1:0] count);
            rect_result_t e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, nothing pending", $time);
                return;
            end
            e = pending.pop_front();
            if (got_in !== e.in_res || nx !== t_coord'(e.nx) || ny !== t_coord'(e.ny) ||
                got_dsq !== e.dsq || status !== e.status || count !== CNT_W'(e.count)) begin
                errors++;
                $display("%0t: exp inside=%0d near=(%0d,%0d) dsq=%0d st=%0d n=%0d", $time,
                         e.in_res, t_coord'(e.nx), t_coord'(e.ny), e.dsq, e.status, e.count);
                $display("%0t: got inside=%0d near=(%0d,%0d) dsq=%0d st=%0d n=%0d", $time,
                         got_in, nx, ny, got_dsq, status, count);
            end
        endfunction
    endclass

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_cfg_we = 0;
    logic [1:0]        i_cfg_idx = CFG_TOL;
    logic [HALF_W-1:0] i_cfg_data = '0;

    rucq_in_if  in_ch();
    rucq_out_if out_ch();

    rect_union_clamp_query uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    rect_scoreboard tables = new();
    bit             calm;      // no idling on either side while set
    int             sent;
    longint         org_x, org_y, grid;

    always #1 i_clk = ~i_clk;

    // Result side: random back-pressure, changed on the falling edge.
    always @(negedge i_clk) begin
        out_ch.ready = calm || ($urandom_range(99) >= 19);
    end

    // Every accepted input transaction feeds the model; every result is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            tables.note_item(in_ch.mode, in_ch.coord_x, in_ch.coord_y,
                             in_ch.rect_width, in_ch.rect_height);
        if (i_rst_n && out_ch.valid && out_ch.ready)
            tables.check(out_ch.inside_res, out_ch.near_x, out_ch.near_y,
                         out_ch.near_dist_sq, out_ch.status, out_ch.entry_count);
    end

    // Valid is left high after acceptance; the next send or a drain decides.
    task automatic send(logic [1:0] mode, logic [23:0] x, logic [23:0] y,
                        logic [22:0] w, logic [22:0] h);
        while (!calm && $urandom_range(99) < 19) begin
            in_ch.valid = 0;
            @(negedge i_clk);
        end
        in_ch.mode = mode;
        in_ch.coord_x = x;
        in_ch.coord_y = y;
        in_ch.rect_width = w;
        in_ch.rect_height = h;
        in_ch.valid = 1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic send_noise();
        send(2'($urandom), 24'($urandom), 24'($urandom), 23'($urandom), 23'($urandom));
    endtask

    // Wait for the block to go idle: all results back, then a short margin.
    task automatic drain();
        in_ch.valid = 0;
        while (tables.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [22:0] v);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = v;
        tables.write_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    // Rectangle on the current grid, one or two cells per side and mostly whole cells so that edges abut.
    task automatic add_grid_rect();
        longint cx, cy, w, h;
        w = grid * $urandom_range(1, 2);
        h = grid * $urandom_range(1, 2);
        if ($urandom_range(9) == 0) w = w + $urandom_range(0, 3) - 1;
        if ($urandom_range(9) == 0) h = h + $urandom_range(0, 3) - 1;
        cx = org_x + grid * $urandom_range(0, 5) + w / 2;
        cy = org_y + grid * $urandom_range(0, 5) + h / 2;
        send(MODE_ADD, 24'(cx), 24'(cy), 23'(w), 23'(h));
    endtask

    task automatic query_point();
        longint px, py;
        int     k;
        px = org_x + $urandom_range(0, 9 * grid) - 2 * grid;
        py = org_y + $urandom_range(0, 9 * grid) - 2 * grid;
        if (tables.held > 0 && $urandom_range(3) == 0) begin
            // exactly on an edge, edges count as inside
            k = $urandom_range(0, tables.held - 1);
            px = $urandom_range(1) ? tables.le[k] : tables.re[k];
            py = $urandom_range(1) ? tables.te[k] : tables.be[k];
        end
        if ($urandom_range(15) == 0) begin
            px = $signed(24'($urandom));
            py = $signed(24'($urandom));
        end
        send(MODE_QUERY, 24'(px), 24'(py), 23'($urandom), 23'($urandom));
    endtask

    // One table: clear, fill, maybe shrink (sometimes twice), query it, and sometimes end with a noise item.
    task automatic table_session();
        int n;
        grid = longint'(1) << $urandom_range(4, 14);
        org_x = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
        org_y = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
        send(MODE_CLEAR, 24'($urandom), 24'($urandom), 23'($urandom), 23'($urandom));
        n = ($urandom_range(39) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++) add_grid_rect();
        if ($urandom_range(1)) begin
            send(MODE_BUILD, 24'($urandom), 24'($urandom), 23'($urandom), 23'($urandom));
            if ($urandom_range(4) == 0)
                send(MODE_BUILD, 24'($urandom), 24'($urandom), 23'($urandom), 23'($urandom));
        end
        repeat ($urandom_range(4, 20)) query_point();
        if ($urandom_range(3) == 0) send_noise();
    endtask

    function automatic logic [22:0] pick_half();
        case ($urandom_range(4))
            0: return 0;
            1: return 23'h7FFFFF;
            2: return 23'($urandom_range(0, 64));
            3: return 23'($urandom_range(0, 4096));
            default: return 23'($urandom);
        endcase
    endfunction

    initial begin
        int phase_end;
        in_ch.valid = 0;
        in_ch.mode = MODE_CLEAR;
        in_ch.coord_x = '0;
        in_ch.coord_y = '0;
        in_ch.rect_width = '0;
        in_ch.rect_height = '0;
        out_ch.ready = 0;
        tables.reset_state();
        calm = 0;
        sent = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Directed: empty table, saturating edges, zero-size box, corners.
        send(MODE_QUERY, 24'h7FFFFF, 24'h800000, 0, 0);
        send(MODE_ADD, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF);
        send(MODE_ADD, 24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF);
        send(MODE_ADD, 24'h000000, 24'h000000, 0, 0);
        send(MODE_QUERY, 24'h000000, 24'h000000, 0, 0);
        send(MODE_QUERY, 24'h7FFFFF, 24'h7FFFFF, 0, 0);
        send(MODE_QUERY, 24'h800000, 24'h800000, 0, 0);
        send(MODE_QUERY, 24'h7FFFFF, 24'h800000, 0, 0);
        send(MODE_QUERY, 24'h800000, 24'h7FFFFF, 0, 0);
        send(MODE_BUILD, 0, 0, 0, 0);
        send(MODE_QUERY, 24'h000100, 24'hFFFF00, 0, 0);
        send(MODE_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 23'h7FFFFF, 23'h7FFFFF);
        send(MODE_QUERY, 24'h123456, 24'hEDCBA9, 0, 0);
        // two abutting cells, then a shrink with a large agent
        send(MODE_ADD, 24'h000080, 24'h000080, 23'h100, 23'h100);
        send(MODE_ADD, 24'h000180, 24'h000080, 23'h100, 23'h100);
        drain();
        write_reg(CFG_HALF_W, 23'h40);
        write_reg(CFG_HALF_H, 23'h7FFFFF);
        send(MODE_BUILD, 0, 0, 0, 0);
        send(MODE_QUERY, 24'h000100, 24'h000080, 0, 0);
        send(MODE_QUERY, 24'hFFFF00, 24'h000300, 0, 0);
        drain();
        write_reg(CFG_TOL, 16'hFFFF);
        write_reg(CFG_HALF_W, 0);
        write_reg(CFG_HALF_H, 0);

        // Random phases, each with its own register setting.
        for (int phase = 0; sent < 1750; phase++) begin
            drain();
            if (phase > 0) begin
                case ($urandom_range(3))
                    0: write_reg(CFG_TOL, 0);
                    1: write_reg(CFG_TOL, 16'hFFFF);
                    default: write_reg(CFG_TOL, 23'($urandom_range(0, 2048)));
                endcase
                write_reg(CFG_HALF_W, pick_half());
                write_reg(CFG_HALF_H, pick_half());
            end
            calm = (phase == 4);
            phase_end = sent + 150;
            while (sent < phase_end && sent < 1750) begin
                if ($urandom_range(9) == 0) send_noise();
                else table_session();
            end
        end
        calm = 0;
        drain();
        repeat (20) @(negedge i_clk);
        if (tables.errors == 0 && tables.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #8000000;
        $display("Mismatches found");
        $finish;
    end
endmodule

`default_nettype wire
